// File: design/ucmc_pkg.sv
`timescale 1ns / 1ps

package ucmc_pkg;

  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] ST_NOT_UDP       = 3'd0;
  localparam logic [2:0] ST_OTHER_PORT    = 3'd1;
  localparam logic [2:0] ST_RESET_DONE    = 3'd2;
  localparam logic [2:0] ST_RESET_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_COUNTED       = 3'd4;
  localparam logic [2:0] ST_FULL          = 3'd5;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [15:0] peer_port;
    logic [15:0] dst_port;
    logic        is_shutdown;
  } packet_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] msg_count;
    logic [3:0]  slot;
  } result_t;

  typedef enum logic [1:0] {
    KIND_NOT_UDP,
    KIND_OTHER_PORT,
    KIND_LOOKUP
  } job_kind_t;

  // Classified packet handed from the front end to the table engine
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] src_ip;
    logic [15:0] peer_port;
    logic        is_shutdown;
  } job_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] count;
  } entry_t;

endpackage

// File: design/udp_client_message_counter.sv
`timescale 1ns / 1ps

// UDP client message counter.
// Input channel: drive the packet header on item and raise start; the transfer
// happens at a rising edge with start high and busy low. busy rises when the
// two-deep job queue between the front end and the table engine is full.
// Output channel: done is high for exactly one cycle with the result on result;
// the receiver cannot stall, so every result must be taken in that cycle.
// Configuration: cfg_we with cfg_data writes the server port; write only while
// idle.
// Packets that are not UDP or target another port are answered from the idle
// state. A table lookup reads slots from slot 0 upward until the client matches,
// and up to the fill count when it is absent (new client, full table or unknown
// shutdown). The engine reads one table slot per cycle from a single-port table
// memory, takes one ignored packet per cycle while no table lookup is under way,
// and takes no new packet from the queue until a lookup is through.
// Reset clears the server port, the queue and the slot fill count; table slots
// are filled from slot 0 upward and never read beyond the fill count, so the
// table needs no clearing pass.
module udp_client_message_counter #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              start,
  input  ucmc_pkg::packet_t item,
  output logic              busy,
  output logic              done,
  output ucmc_pkg::result_t result
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  ucmc_pkg::job_t push_job;
  ucmc_pkg::job_t head_job;

  // Hold the server port and classify each packet on transfer
  ucmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .start    (start),
    .item     (item),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .job      (push_job)
  );

  // Decouple intake from the table walk
  ucmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (head_job)
  );

  // Search, append or clear clients and advance counts
  ucmc_engine #(
    .TableDepth (TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (head_job),
    .pop         (pop),
    .done        (done),
    .result      (result)
  );

endmodule

// File: design/ucmc_front.sv
`timescale 1ns / 1ps

module ucmc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  logic             start,
  input  ucmc_pkg::packet_t item,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output ucmc_pkg::job_t   job
);

  logic [15:0] listen_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= 16'd0;
    end else if (cfg_we) begin
      listen_port <= cfg_data;
    end
  end

  assign busy = q_full;
  assign push = start && !q_full;

  // Classify on the way in; only UDP to the server port needs the table
  always_comb begin
    job.src_ip      = item.src_ip;
    job.peer_port   = item.peer_port;
    job.is_shutdown = item.is_shutdown;
    if (item.protocol != ucmc_pkg::PROTO_UDP) begin
      job.kind = ucmc_pkg::KIND_NOT_UDP;
    end else if (item.dst_port != listen_port) begin
      job.kind = ucmc_pkg::KIND_OTHER_PORT;
    end else begin
      job.kind = ucmc_pkg::KIND_LOOKUP;
    end
  end

endmodule

// File: design/ucmc_queue.sv
`timescale 1ns / 1ps

module ucmc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ucmc_pkg::job_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ucmc_pkg::job_t head_data
);

  ucmc_pkg::job_t slots [2];
  logic           head;
  logic           tail;
  logic [1:0]     fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head_data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/ucmc_engine.sv
`timescale 1ns / 1ps

module ucmc_engine #(
  parameter int TableDepth = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  ucmc_pkg::job_t    q_data,
  output logic              pop,
  output logic              done,
  output ucmc_pkg::result_t result
);

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t                state;
  ucmc_pkg::job_t        job;
  logic [CntW-1:0]       used;
  logic [CntW-1:0]       issue_idx;
  logic                  pend;
  logic [IdxW-1:0]       pend_idx;

  ucmc_pkg::entry_t      mem [TableDepth];
  ucmc_pkg::entry_t      rd_data;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_idx;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  ucmc_pkg::entry_t      wr_data;

  logic                  match;
  logic                  issue_ok;
  logic                  has_room;
  logic [31:0]           inc_count;

  function automatic logic [3:0] low_slot(input logic [IdxW-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[3:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  assign pop       = (state == S_IDLE) && q_not_empty;
  assign match     = pend && (rd_data.addr == job.src_ip) && (rd_data.port == job.peer_port);
  assign issue_ok  = (issue_idx < used);
  assign has_room  = (used != CntW'(TableDepth));
  assign inc_count = (rd_data.count == ucmc_pkg::COUNT_MAX) ? ucmc_pkg::COUNT_MAX
                                                             : rd_data.count + 32'd1;

  // Walk the filled slots one read a cycle, compare each read in the cycle after it, then update the match or append
  always_comb begin
    rd_en        = 1'b0;
    rd_idx       = issue_idx[IdxW-1:0];
    wr_en        = 1'b0;
    wr_idx       = pend_idx;
    wr_data.addr = job.src_ip;
    wr_data.port = job.peer_port;
    wr_data.count = job.is_shutdown ? 32'd0 : inc_count;
    if (state == S_SEARCH) begin
      if (match) begin
        wr_en = 1'b1;
      end else if (issue_ok) begin
        rd_en = 1'b1;
      end else if (!job.is_shutdown && has_room) begin
        wr_en         = 1'b1;
        wr_idx        = used[IdxW-1:0];
        wr_data.count = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      used      <= '0;
      issue_idx <= '0;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            job <= q_data;
            case (q_data.kind)
              ucmc_pkg::KIND_NOT_UDP: begin
                done   <= 1'b1;
                result <= '{ucmc_pkg::ST_NOT_UDP, 32'd0, 4'd0};
              end
              ucmc_pkg::KIND_OTHER_PORT: begin
                done   <= 1'b1;
                result <= '{ucmc_pkg::ST_OTHER_PORT, 32'd0, 4'd0};
              end
              default: begin
                done      <= 1'b0;
                issue_idx <= '0;
                pend      <= 1'b0;
                state     <= S_SEARCH;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (match) begin
            done  <= 1'b1;
            pend  <= 1'b0;
            state <= S_IDLE;
            if (job.is_shutdown) begin
              result <= '{ucmc_pkg::ST_RESET_DONE, 32'd0, low_slot(pend_idx)};
            end else begin
              result <= '{ucmc_pkg::ST_COUNTED, inc_count, low_slot(pend_idx)};
            end
          end else if (issue_ok) begin
            done      <= 1'b0;
            pend      <= 1'b1;
            pend_idx  <= issue_idx[IdxW-1:0];
            issue_idx <= issue_idx + CntW'(1);
          end else begin
            done  <= 1'b1;
            pend  <= 1'b0;
            state <= S_IDLE;
            if (job.is_shutdown) begin
              result <= '{ucmc_pkg::ST_RESET_UNKNOWN, 32'd0, 4'd0};
            end else if (!has_room) begin
              result <= '{ucmc_pkg::ST_FULL, 32'd0, 4'd0};
            end else begin
              result <= '{ucmc_pkg::ST_COUNTED, 32'd1, low_slot(used[IdxW-1:0])};
              used   <= used + CntW'(1);
            end
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
